### rtl/pcpa_pkg.sv
// Shared constants, codes and helper functions for the per-CPU page free-list allocator.
`default_nettype none

package pcpa_pkg;

    localparam int CPU_COUNT  = 8;
    localparam int PAGE_COUNT = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int ADDR_W  = 40;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int CPU_W   = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int OFS_W   = $clog2(PAGE_BYTES);
    localparam int PFN_W   = ADDR_W - OFS_W;
    localparam int LINK_W  = PAGE_W + 1;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_DATA_W  = ((REQ_W + ADDR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ADDR_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;

    localparam logic [ADDR_W-1:0] LOW_LIMIT_RESET  = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] HIGH_LIMIT_RESET = 40'h00_8800_0000;

    // Request kinds.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_ALLOC = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FREED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd3;

    typedef logic [CPU_W-1:0]  cpu_t;
    typedef logic [PAGE_W-1:0] page_t;

    // Folds a requester index into the range of CPUs by repeated subtraction.
    function automatic cpu_t cpu_of(input logic [REQ_W-1:0] requester);
        logic [REQ_W-1:0] v;
        v = requester;
        for (int i = 0; i < (1 << REQ_W); i++)
        begin
            if (int'(v) >= CPU_COUNT)
                v = v - REQ_W'(CPU_COUNT);
        end
        return CPU_W'(v);
    endfunction

endpackage

`default_nettype wire

### rtl/per_cpu_page_free_list_allocator.sv
// Top level of the per-CPU page free-list allocator with list stealing.
// A request passes the check state (single link memory read), then the finish state, which
// waits while a result is unaccepted at the output; new requests are taken only when idle.
// A result waiting at the output does not block the next input transfer.
// Reset: all per-CPU lists empty and the limits at their defaults; the link memory is not
// cleared, since every entry is written when its page is pushed, before it can be read.
`default_nettype none

module per_cpu_page_free_list_allocator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pcpa_pkg::ADDR_W-1:0]       cfg_data,
    // Request stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pcpa_pkg::IN_DATA_W-1:0]    s_tdata,  // requester[2:0], page_address[42:3]
    input  wire logic                              s_tuser,  // operation[0]
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [pcpa_pkg::OUT_DATA_W-1:0]        m_tdata,  // granted_address[39:0]
    output logic [pcpa_pkg::STAT_W-1:0]            m_tuser   // status[1:0]
);
    import pcpa_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;

    logic [ADDR_W-1:0]  low_limit_reg;
    logic [ADDR_W-1:0]  high_limit_reg;

    // Request registers.
    logic               op_reg;
    cpu_t               cpu_reg;
    logic [ADDR_W-1:0]  addr_reg;

    // Results of the check cycle.
    logic               bad_reg;
    page_t              page_reg;
    logic               found_reg;
    cpu_t               src_reg;

    // List heads: valid bits and page numbers.
    logic [CPU_COUNT-1:0] list_valid_reg;
    page_t                list_page_reg [CPU_COUNT];

    // Shared next-link memory: valid bit above the next page number.
    logic [LINK_W-1:0]  link_mem [PAGE_COUNT];
    logic [LINK_W-1:0]  link_rd_reg;

    // Output register.
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [STAT_W-1:0]  out_status_reg;

    logic               in_xfer;
    logic               advance;
    logic               scan_found;
    cpu_t               scan_src;
    cpu_t               scan_idx;
    logic [PFN_W-1:0]   base_pfn;
    logic [PFN_W:0]     pfn_diff;
    logic               free_ok;
    logic [PFN_W-1:0]   grant_pfn;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign advance   = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_addr_reg);
    assign m_tuser  = out_status_reg;

    // Search for the first non-empty list, starting at the requester's own.
    always_comb
    begin
        scan_found = 1'b0;
        scan_src   = cpu_reg;
        scan_idx   = cpu_reg;
        for (int i = 0; i < CPU_COUNT; i++)
        begin
            if (!scan_found && list_valid_reg[scan_idx])
            begin
                scan_found = 1'b1;
                scan_src   = scan_idx;
            end
            scan_idx = (scan_idx == CPU_W'(CPU_COUNT - 1)) ? '0 : scan_idx + 1'b1;
        end
    end

    // Free address checks; the page number is taken relative to the low limit.
    assign base_pfn = low_limit_reg[ADDR_W-1:OFS_W];
    assign pfn_diff = {1'b0, addr_reg[ADDR_W-1:OFS_W]} - {1'b0, base_pfn};
    assign free_ok  = (addr_reg[OFS_W-1:0] == '0) &&
                      (addr_reg >= low_limit_reg) &&
                      (addr_reg < high_limit_reg) &&
                      !pfn_diff[PFN_W] &&
                      (pfn_diff[PFN_W-1:0] < PFN_W'(PAGE_COUNT));

    assign grant_pfn = base_pfn + PFN_W'(list_page_reg[src_reg]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (advance)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_limit_reg  <= LOW_LIMIT_RESET;
            high_limit_reg <= HIGH_LIMIT_RESET;
            list_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_LOW_LIMIT:  low_limit_reg  <= cfg_data;
                    REG_HIGH_LIMIT: high_limit_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (advance)
            begin
                if (op_reg == OP_FREE)
                begin
                    if (!bad_reg)
                        list_valid_reg[cpu_reg] <= 1'b1;
                end
                else if (found_reg)
                begin
                    // The requester's own entry is written last, so it wins when the
                    // victim is the requester itself.
                    list_valid_reg[src_reg] <= 1'b0;
                    list_valid_reg[cpu_reg] <= link_rd_reg[LINK_W-1];
                end
            end

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, list head page numbers and the link memory.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= s_tuser;
            cpu_reg  <= cpu_of(s_tdata[REQ_W-1:0]);
            addr_reg <= s_tdata[REQ_W +: ADDR_W];
        end

        if (state_reg == ST_CHECK)
        begin
            bad_reg     <= !free_ok;
            page_reg    <= page_t'(pfn_diff[PFN_W-1:0]);
            found_reg   <= scan_found;
            src_reg     <= scan_src;
            link_rd_reg <= link_mem[list_page_reg[scan_src]];
        end

        if (advance)
        begin
            if (op_reg == OP_FREE)
            begin
                if (!bad_reg)
                begin
                    link_mem[page_reg]     <= {list_valid_reg[cpu_reg], list_page_reg[cpu_reg]};
                    list_page_reg[cpu_reg] <= page_reg;
                end
                out_addr_reg   <= '0;
                out_status_reg <= bad_reg ? STAT_BAD : STAT_FREED;
            end
            else if (found_reg)
            begin
                list_page_reg[cpu_reg] <= link_rd_reg[PAGE_W-1:0];
                out_addr_reg           <= {grant_pfn, {OFS_W{1'b0}}};
                out_status_reg         <= STAT_ALLOC;
            end
            else
            begin
                out_addr_reg   <= '0;
                out_status_reg <= STAT_OOM;
            end
        end
    end

    // A finished request always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("finished request did not produce a result");

    // Only a successful allocation carries an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != STAT_ALLOC)) |-> (m_tdata == '0))
        else $error("non-allocation result carries an address");

    // A good free leaves the requester's list non-empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg == OP_FREE) && !bad_reg) |=> list_valid_reg[$past(cpu_reg)])
        else $error("freed page missing from the requester's list");

    // No new request is taken while one is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |=> (state_reg == ST_FINISH) && !s_tready)
        else $error("request pipeline sequencing broken");

endmodule

`default_nettype wire

### verif/tb_per_cpu_page_free_list_allocator.sv
// Self-checking testbench for the per-CPU page free-list allocator with list stealing.
`timescale 1ns / 100ps

module tb_per_cpu_page_free_list_allocator;
    import pcpa_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
    localparam logic [ADDR_W-1:0] TOP_LOW  = ADDR_MAX - PAGE_COUNT * PAGE_BYTES + 1;
    localparam logic [ADDR_W-1:0] ODD_LOW  = 40'h00_4567_8ABC;

    typedef struct packed {
        bit                valid;
        bit [PAGE_W-1:0]   page;
    } list_ref_t;

    typedef struct {
        logic [ADDR_W-1:0] granted;
        logic [STAT_W-1:0] status;
    } alloc_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ADDR_W-1:0]     cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    // Shadow copy of the allocator state and its limit registers.
    list_ref_t             cpu_heads [CPU_COUNT];
    list_ref_t             page_links [PAGE_COUNT];
    bit                    page_listed [PAGE_COUNT];
    logic [ADDR_W-1:0]     low_limit_q  = LOW_LIMIT_RESET;
    logic [ADDR_W-1:0]     high_limit_q = HIGH_LIMIT_RESET;

    alloc_result_t         expected_results [$];
    alloc_result_t         oldest_result;
    int unsigned           mismatch_count = 0;
    int unsigned           burst_left     = 0;
    int unsigned           stall_mode     = 0;
    int unsigned           stall_left     = 0;

    always #1 clk = ~clk;

    per_cpu_page_free_list_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Applies one request to the shadow state and returns the result it should produce.
    function automatic alloc_result_t apply_request(logic op, logic [REQ_W-1:0] requester,
                                                    logic [ADDR_W-1:0] addr);
        longint unsigned pfn;
        longint unsigned base;
        longint unsigned page_no;
        int unsigned     cpu;
        int unsigned     src;
        bit              found;
        alloc_result_t   res;
        cpu         = requester % CPU_COUNT;
        base        = low_limit_q / PAGE_BYTES;
        pfn         = addr / PAGE_BYTES;
        res.granted = '0;
        if (op == OP_FREE)
        begin
            if (addr % PAGE_BYTES != 0 || addr < low_limit_q || addr >= high_limit_q ||
                pfn < base || pfn - base >= PAGE_COUNT)
                res.status = STAT_BAD;
            else
            begin
                page_no              = pfn - base;
                page_links[page_no]  = cpu_heads[cpu];
                cpu_heads[cpu]       = {1'b1, page_no[PAGE_W-1:0]};
                page_listed[page_no] = 1'b1;
                res.status           = STAT_FREED;
            end
        end
        else
        begin
            found = 1'b0;
            src   = cpu;
            for (int i = 0; i < CPU_COUNT && !found; i++)
            begin
                src   = (cpu + i) % CPU_COUNT;
                found = cpu_heads[src].valid;
            end
            if (found)
            begin
                // The whole victim list moves over; its first page is granted.
                page_no              = cpu_heads[src].page;
                cpu_heads[src]       = '0;
                cpu_heads[cpu]       = page_links[page_no];
                page_listed[page_no] = 1'b0;
                res.granted          = ADDR_W'((base + page_no) * PAGE_BYTES);
                res.status           = STAT_ALLOC;
            end
            else
                res.status = STAT_OOM;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Sends one request, with a random gap between bursts of transfers.
    task automatic send_request(logic op, logic [REQ_W-1:0] requester, logic [ADDR_W-1:0] addr);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'({addr, requester});
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(apply_request(op, requester, addr));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Both limits are written back to back while the allocator is idle.
    task automatic set_limits(logic [ADDR_W-1:0] low, logic [ADDR_W-1:0] high);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= REG_LOW_LIMIT;
        cfg_data  <= low;
        do
            @(posedge clk);
        while (!cfg_ready);
        low_limit_q = low;
        cfg_index <= REG_HIGH_LIMIT;
        cfg_data  <= high;
        do
            @(posedge clk);
        while (!cfg_ready);
        high_limit_q = high;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_free_checks();
        send_request(OP_FREE, 3'd0, LOW_LIMIT_RESET);
        send_request(OP_FREE, 3'd7, HIGH_LIMIT_RESET - PAGE_BYTES);
        send_request(OP_FREE, 3'd1, HIGH_LIMIT_RESET);
        send_request(OP_FREE, 3'd1, LOW_LIMIT_RESET - PAGE_BYTES);
        send_request(OP_FREE, 3'd1, LOW_LIMIT_RESET + PAGE_BYTES / 2);
        send_request(OP_FREE, 3'd1, ADDR_MAX);
    endtask

    task automatic test_alloc_and_steal();
        send_request(OP_ALLOC, 3'd0, '0);
        send_request(OP_ALLOC, 3'd0, ADDR_MAX);
        send_request(OP_ALLOC, 3'd3, '0);
        send_request(OP_FREE, 3'd1, LOW_LIMIT_RESET + 16 * PAGE_BYTES);
        // The scan from CPU 6 wraps round through 7 and 0 before finding CPU 1.
        send_request(OP_ALLOC, 3'd6, '0);
    endtask

    // The same page freed on two CPUs is granted twice.
    task automatic test_double_free();
        send_request(OP_FREE, 3'd2, LOW_LIMIT_RESET + 5 * PAGE_BYTES);
        send_request(OP_FREE, 3'd3, LOW_LIMIT_RESET + 5 * PAGE_BYTES);
        send_request(OP_ALLOC, 3'd2, '0);
        send_request(OP_ALLOC, 3'd3, '0);
        send_request(OP_ALLOC, 3'd3, '0);
    endtask

    task automatic test_limit_extremes();
        set_limits('0, ADDR_MAX);
        send_request(OP_FREE, 3'd4, '0);
        send_request(OP_FREE, 3'd4, (PAGE_COUNT - 1) * PAGE_BYTES);
        send_request(OP_FREE, 3'd4, PAGE_COUNT * PAGE_BYTES);
        // Pages stay listed while the low limit moves, so grants follow the new base.
        set_limits(40'h10_0000_0000, ADDR_MAX);
        send_request(OP_ALLOC, 3'd4, '0);
        send_request(OP_ALLOC, 3'd5, '0);
        set_limits(TOP_LOW, ADDR_MAX);
        send_request(OP_FREE, 3'd7, ADDR_MAX & ~ADDR_W'(PAGE_BYTES - 1));
        send_request(OP_ALLOC, 3'd7, '0);
        set_limits(ADDR_MAX, '0);
        send_request(OP_FREE, 3'd0, ADDR_MAX & ~ADDR_W'(PAGE_BYTES - 1));
        send_request(OP_ALLOC, 3'd0, '0);
        set_limits(40'h00_1234_5678, 40'h00_1244_5678);
        send_request(OP_FREE, 3'd1, 40'h00_1234_5000);
        send_request(OP_FREE, 3'd1, 40'h00_1234_6000);
    endtask

    // Mostly frees of unlisted pages and allocations, with malformed frees as noise.
    task automatic test_random_traffic(int unsigned count, int unsigned double_pct);
        logic [ADDR_W-1:0] addr;
        logic              op;
        logic [REQ_W-1:0]  requester;
        longint unsigned   base;
        longint unsigned   page_no;
        int unsigned       pick;
        for (int unsigned n = 0; n < count; n++)
        begin
            base      = low_limit_q / PAGE_BYTES;
            requester = $urandom_range(0, 7);
            addr      = ADDR_W'({$urandom(), $urandom()});
            pick      = $urandom_range(0, 99);
            page_no   = $urandom_range(0, 1) ? $urandom_range(0, 63)
                                             : $urandom_range(0, PAGE_COUNT - 1);
            op        = OP_ALLOC;
            if (pick < 40)
            begin
                if (!page_listed[page_no] || $urandom_range(0, 99) < double_pct)
                begin
                    op   = OP_FREE;
                    addr = ADDR_W'((base + page_no) * PAGE_BYTES);
                end
            end
            else if (pick >= 85)
            begin
                op = OP_FREE;
                case ($urandom_range(0, 3))
                    0: ;
                    1: addr = ADDR_W'((base + page_no) * PAGE_BYTES) |
                              ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
                    2: addr = low_limit_q - PAGE_BYTES;
                    default: addr = high_limit_q & ~ADDR_W'(PAGE_BYTES - 1);
                endcase
            end
            send_request(op, requester, addr);
            if (n == count / 2)
                wait_drained();
        end
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", m_tdata, '0);
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (m_tdata[ADDR_W-1:0] !== oldest_result.granted)
                        report_mismatch("granted address", m_tdata, oldest_result.granted);
                    if (m_tuser !== oldest_result.status)
                        report_mismatch("status", m_tuser, oldest_result.status);
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(16, 80);
            end
            else
                stall_left--;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_free_checks();
        test_alloc_and_steal();
        test_double_free();
        test_limit_extremes();
        set_limits(LOW_LIMIT_RESET, HIGH_LIMIT_RESET);
        test_random_traffic(450, 0);
        set_limits('0, ADDR_MAX);
        test_random_traffic(350, 0);
        set_limits(TOP_LOW, ADDR_MAX);
        test_random_traffic(300, 0);
        set_limits(ODD_LOW, ODD_LOW + 20000 * PAGE_BYTES);
        test_random_traffic(350, 5);
        s_tvalid <= 1'b0;
        for (int unsigned w = 0; w < 4000 && expected_results.size() != 0; w++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), '0);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
